/* design/mva_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mean and variance accumulator package
// Field widths, controller states and the command word from the controller
// to the datapath.
// ----------------------------------------------------------------------------
package mva_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int MEAN_W      = 24;
	localparam int VAR_W       = 39;
	localparam int COUNT_OUT_W = 13;
	localparam int FRAC_W      = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LOAD_MEAN,
		ST_DIV_MEAN,
		ST_LOAD_VAR,
		ST_DIV_VAR,
		ST_FINISH
	} mva_state_t;

	typedef struct packed {
		logic accum;
		logic capture;
		logic mul_step;
		logic load_mean;
		logic div_step;
		logic load_var;
		logic out_load;
	} mva_cmd_t;

endpackage : mva_pkg
`default_nettype wire

/* design/mva_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mean and variance accumulator channels
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface mva_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [mva_pkg::SAMPLE_W-1:0] sample;
	logic                                last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface : mva_in_if

interface mva_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [mva_pkg::MEAN_W-1:0]     mean_out;
	logic        [mva_pkg::VAR_W-1:0]      variance_out;
	logic        [mva_pkg::COUNT_OUT_W-1:0] sample_count;

	modport source (output valid, output mean_out, output variance_out,
		output sample_count, input ready);
	modport sink   (input valid, input mean_out, input variance_out,
		input sample_count, output ready);
endinterface : mva_out_if

interface mva_cfg_if;
	logic valid;
	logic ready;
	logic unbiased_mode;

	modport source (output valid, output unbiased_mode, input ready);
	modport sink   (input valid, input unbiased_mode, output ready);
endinterface : mva_cfg_if
`default_nettype wire

/* design/mva_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mean and variance accumulator controller
// Sequences accumulation, the serial multiply and the two divisions.
// ----------------------------------------------------------------------------
module mva_ctrl #(
	parameter int MUL_STEPS = 13,
	parameter int DIV_STEPS = 66
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	input  wire              in_last,
	output logic             in_ready,
	output logic             out_valid,
	input  wire              out_ready,
	output mva_pkg::mva_cmd_t cmd
);

	localparam int STEP_W = $clog2(DIV_STEPS);

	mva_pkg::mva_state_t state_q, state_d;
	logic [STEP_W-1:0]   step_q, step_d;
	logic                out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mva_pkg::ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			mva_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accum = 1'b1;
					if (in_last) begin
						cmd.capture = 1'b1;
						step_d      = STEP_W'(MUL_STEPS - 1);
						state_d     = mva_pkg::ST_MUL;
					end
				end
			end
			mva_pkg::ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (step_q == '0) begin
					state_d = mva_pkg::ST_LOAD_MEAN;
				end else begin
					step_d = step_q - 1'b1;
				end
			end
			mva_pkg::ST_LOAD_MEAN: begin
				cmd.load_mean = 1'b1;
				step_d        = STEP_W'(DIV_STEPS - 1);
				state_d       = mva_pkg::ST_DIV_MEAN;
			end
			mva_pkg::ST_DIV_MEAN: begin
				cmd.div_step = 1'b1;
				if (step_q == '0) begin
					state_d = mva_pkg::ST_LOAD_VAR;
				end else begin
					step_d = step_q - 1'b1;
				end
			end
			mva_pkg::ST_LOAD_VAR: begin
				cmd.load_var = 1'b1;
				step_d       = STEP_W'(DIV_STEPS - 1);
				state_d      = mva_pkg::ST_DIV_VAR;
			end
			mva_pkg::ST_DIV_VAR: begin
				cmd.div_step = 1'b1;
				if (step_q == '0) begin
					state_d = mva_pkg::ST_FINISH;
				end else begin
					step_d = step_q - 1'b1;
				end
			end
			mva_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = mva_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mva_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule : mva_ctrl
`default_nettype wire

/* design/mva_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mean and variance accumulator datapath
// Accumulators, shift-add multiplier, restoring divider and result register.
// ----------------------------------------------------------------------------
module mva_dp #(
	parameter int MAX_COUNT = 4096
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  mva_pkg::mva_cmd_t                       cmd,
	input  wire signed [mva_pkg::SAMPLE_W-1:0]      sample,
	input  wire                                     cfg_we,
	input  wire                                     cfg_data,
	output logic signed [mva_pkg::MEAN_W-1:0]       mean_out,
	output logic        [mva_pkg::VAR_W-1:0]        variance_out,
	output logic        [mva_pkg::COUNT_OUT_W-1:0]  sample_count
);

	localparam int SW     = mva_pkg::SAMPLE_W;
	localparam int CNT_W  = $clog2(MAX_COUNT + 1);
	localparam int SUM_W  = CNT_W + SW;
	localparam int SQ_W   = CNT_W + 2 * SW - 1;
	localparam int PROD_W = CNT_W + SQ_W;
	localparam int NUM_W  = 2 * SUM_W;
	localparam int DEN_W  = 2 * CNT_W;
	localparam int DIVD_W = NUM_W + mva_pkg::FRAC_W;

	logic                    unbiased_q;
	logic signed [SUM_W-1:0] sum_q, sum_d;
	logic [SQ_W-1:0]         sq_q, sq_d;
	logic [CNT_W-1:0]        cnt_q, cnt_d;

	logic signed [2*SW-1:0]  smul;
	logic signed [SUM_W-1:0] sample_ext;

	logic signed [SUM_W-1:0] sum_w_q;
	logic [SQ_W-1:0]         sq_w_q;
	logic [CNT_W-1:0]        n_q;
	logic [CNT_W-1:0]        mplier_q;
	logic [PROD_W-1:0]       prod_q;
	logic [SUM_W-1:0]        sum_mag_q;
	logic [NUM_W-1:0]        ss_q;
	logic [DEN_W-1:0]        den_q;
	logic [CNT_W-1:0]        n_factor;

	logic [DEN_W-1:0]        rem_q;
	logic [DIVD_W-1:0]       quo_q;
	logic [DEN_W-1:0]        dvsr_q;
	logic [DEN_W:0]          trial;
	logic                    trial_ok;

	logic [NUM_W-1:0]        prod_ext;
	logic [NUM_W-1:0]        num;
	logic                    var_zero_q;
	logic [mva_pkg::MEAN_W-1:0] mean_q, mean_mag;
	logic [CNT_W+mva_pkg::COUNT_OUT_W-1:0] n_ext;

	assign smul       = (2 * SW)'(sample) * (2 * SW)'(sample);
	assign sample_ext = {{(SUM_W - SW){sample[SW-1]}}, sample};

	always_comb begin
		sum_d = sum_q;
		sq_d  = sq_q;
		cnt_d = cnt_q;
		if (cmd.accum && (cnt_q != CNT_W'(MAX_COUNT))) begin
			sum_d = sum_q + sample_ext;
			sq_d  = sq_q + {{(SQ_W - 2 * SW){1'b0}}, smul};
			cnt_d = cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unbiased_q <= 1'b0;
			sum_q      <= '0;
			sq_q       <= '0;
			cnt_q      <= '0;
		end else begin
			if (cfg_we) begin
				unbiased_q <= cfg_data;
			end
			if (cmd.capture) begin
				sum_q <= '0;
				sq_q  <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_d;
				sq_q  <= sq_d;
				cnt_q <= cnt_d;
			end
		end
	end

	assign n_factor = unbiased_q ? (n_q - 1'b1) : n_q;

	// The snapshot only changes on capture, so the square and denominator
	// products settle during the serial multiply.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sum_w_q  <= sum_d;
			sq_w_q   <= sq_d;
			n_q      <= cnt_d;
			mplier_q <= cnt_d;
			prod_q   <= '0;
		end else if (cmd.mul_step) begin
			prod_q   <= {prod_q[PROD_W-2:0], 1'b0}
				+ (mplier_q[CNT_W-1] ? {{(PROD_W - SQ_W){1'b0}}, sq_w_q} : '0);
			mplier_q <= {mplier_q[CNT_W-2:0], 1'b0};
		end
		sum_mag_q <= sum_w_q[SUM_W-1] ? SUM_W'(-sum_w_q) : SUM_W'(sum_w_q);
		ss_q      <= NUM_W'(sum_mag_q) * NUM_W'(sum_mag_q);
		den_q     <= DEN_W'(n_q) * DEN_W'(n_factor);
	end

	assign prod_ext = {{(NUM_W - PROD_W){1'b0}}, prod_q};
	assign num      = prod_ext - ss_q;
	assign trial    = {rem_q, quo_q[DIVD_W-1]};
	assign trial_ok = trial >= {1'b0, dvsr_q};
	assign mean_mag = quo_q[mva_pkg::MEAN_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_mean) begin
			rem_q  <= '0;
			quo_q  <= {{(DIVD_W - SUM_W - mva_pkg::FRAC_W){1'b0}}, sum_mag_q,
				{mva_pkg::FRAC_W{1'b0}}};
			dvsr_q <= {{(DEN_W - CNT_W){1'b0}}, n_q};
		end else if (cmd.load_var) begin
			mean_q     <= sum_w_q[SUM_W-1] ? (~mean_mag + 1'b1) : mean_mag;
			var_zero_q <= (prod_ext <= ss_q) || (unbiased_q && (n_q == CNT_W'(1)));
			rem_q      <= '0;
			quo_q      <= {num, {mva_pkg::FRAC_W{1'b0}}};
			dvsr_q     <= den_q;
		end else if (cmd.div_step) begin
			rem_q <= trial_ok ? DEN_W'(trial - {1'b0, dvsr_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], trial_ok};
		end
	end

	assign n_ext = {{mva_pkg::COUNT_OUT_W{1'b0}}, n_q};

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mean_out     <= mean_q;
			sample_count <= n_ext[mva_pkg::COUNT_OUT_W-1:0];
			if (var_zero_q) begin
				variance_out <= '0;
			end else if (|quo_q[DIVD_W-1:mva_pkg::VAR_W]) begin
				variance_out <= '1;
			end else begin
				variance_out <= quo_q[mva_pkg::VAR_W-1:0];
			end
		end
	end

endmodule : mva_dp
`default_nettype wire

/* design/mean_variance_accumulator_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Samples that are not marked last are taken one per cycle while the controller is idle.
// A last sample starts the result: a shift-add multiply by the CNT_W-bit count and two restoring
// divisions of 2*SUM_W+8 quotient bits each, one quotient bit per cycle, each after a load state.
// A finish state then loads the result; input is held off until it is loaded.
// Reset clears the accumulators, the mode register, the controller and the output valid.
// ----------------------------------------------------------------------------
// Mean and variance accumulator
// Running count, sum and sum of squares with a fixed-point mean and variance per vector.
// ----------------------------------------------------------------------------
module mean_variance_accumulator_top #(
	parameter int MAX_COUNT = 4096
) (
	input wire        clk,
	input wire        arst_n,
	mva_in_if.sink    din,
	mva_out_if.source dout,
	mva_cfg_if.sink   cfg
);

	localparam int CNT_W     = $clog2(MAX_COUNT + 1);
	localparam int SUM_W     = CNT_W + mva_pkg::SAMPLE_W;
	localparam int DIV_STEPS = 2 * SUM_W + mva_pkg::FRAC_W;

	mva_pkg::mva_cmd_t cmd;

	assign cfg.ready = 1'b1;

	mva_ctrl #(
		.MUL_STEPS (CNT_W),
		.DIV_STEPS (DIV_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_last   (din.last_sample),
		.in_ready  (din.ready),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.cmd       (cmd)
	);

	mva_dp #(
		.MAX_COUNT (MAX_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample       (din.sample),
		.cfg_we       (cfg.valid),
		.cfg_data     (cfg.unbiased_mode),
		.mean_out     (dout.mean_out),
		.variance_out (dout.variance_out),
		.sample_count (dout.sample_count)
	);

endmodule : mean_variance_accumulator_top
`default_nettype wire
